### sv/bif_pkg.sv
// Shared types and constants of the bilateral image filter.
package bif_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int NUM_OUT_CH = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPATIAL_COEF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_COEF   = 3'd4;

  // Request codes.
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_FILTER = 1'b1;

  // Register values after reset.
  localparam logic [8:0]  RST_IMAGE_WIDTH  = 9'd256;
  localparam logic [8:0]  RST_IMAGE_HEIGHT = 9'd256;
  localparam logic [3:0]  RST_WINDOW_SIZE  = 4'd3;
  localparam logic [23:0] RST_SPATIAL_COEF = 24'd32768;
  localparam logic [31:0] RST_COLOR_COEF   = 32'd65536;

  // Fixed-point constants of the exponential.
  localparam logic [17:0] LOG2E_Q16 = 18'd94548;
  localparam longint     LN2_Q30   = 64'd744261118;
  localparam longint     ONE_Q30   = 64'd1073741824;
  localparam int         EXP_ARG_W = 21;           // arguments at or above 32.0 give zero
  localparam logic [16:0] EXP_ONE  = 17'h10000;

  // Quotient bits of the final division; the rounded mean never exceeds 32768.
  localparam int Q_BITS = 17;

  typedef struct packed {
    logic               req_type;
    logic [7:0]         pos_x;
    logic [7:0]         pos_y;
    logic signed [15:0] sample_ch0;
    logic signed [15:0] sample_ch1;
    logic signed [15:0] sample_ch2;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         out_x;
    logic [7:0]         out_y;
    logic signed [15:0] filtered_ch0;
    logic signed [15:0] filtered_ch1;
    logic signed [15:0] filtered_ch2;
  } out_item_t;

endpackage

### sv/bif_in_if.sv
// Request channel of the bilateral image filter: valid, ready and one request.
interface bif_in_if;
  logic               valid;
  logic               ready;
  bif_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/bif_out_if.sv
// Result channel of the bilateral image filter: valid, ready and one filtered pixel.
interface bif_out_if;
  logic               valid;
  logic               ready;
  bif_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/bilateral_image_filter.sv
// Bilateral image filter over a frame store, built around one shared multiplier.
//
// Usage: in_stream carries requests. A load transaction writes the three samples of
// one pixel into the frame store in the cycle it is accepted and gives no result;
// positions outside the store are ignored. A filter transaction asks for the
// filtered pixel at (pos_x, pos_y) and gives exactly one transaction on out_stream.
// cfg_we with cfg_index and cfg_wdata writes a register; write only while idle.
// A filter request with window size S and C channels is worked through in order by
// the single multiplier that every product passes through and by the frame store
// read port: the spatial kernel for each of the S offsets, the home pixel, each
// window tap with its C channel differences, colour and spatial weights and C
// accumulations, then a bit-serial divider per channel and the output register.
// A load leaves the block idle. in_stream.ready is high only while idle.
// A finished result sits in the output register; the block takes the next request
// while it waits. If the receiver still stalls the earlier result when a new one is
// finished, the block holds the new one until the register frees up.
// Reset sets the registers to their documented defaults and empties the output
// register; the frame store holds no defined data until it is loaded.
module bilateral_image_filter #(
  parameter int MAX_WIDTH       = 256,
  parameter int MAX_HEIGHT      = 256,
  parameter int CHANNELS        = 3,
  parameter int MAX_WINDOW      = 15,
  parameter int EXP_TABLE_DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  bif_in_if.sink                            in_stream,
  bif_out_if.source                         out_stream,
  input  logic                              cfg_we,
  input  logic [bif_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bif_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int SW_       = bif_pkg::SAMPLE_W;
  localparam int MEM_W     = CHANNELS * SW_;
  localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int IW        = $clog2(MAX_WINDOW + 1);
  localparam int GK_AW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CH_AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TAB_AW    = (EXP_TABLE_DEPTH > 1) ? $clog2(EXP_TABLE_DEPTH) : 1;
  localparam int WIN2_W    = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int WSUM_W    = 33 + WIN2_W;
  localparam int VSUM_W    = WSUM_W + 16;
  localparam int QB        = bif_pkg::Q_BITS;

  typedef logic [16:0] exp_rom_t [EXP_TABLE_DEPTH];

  // Table of 2^(-i/DEPTH) in Q16 from a Taylor series of exp(-z), z in Q30.
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t          rom;
    logic [63:0]       z;
    logic [63:0]       term;
    logic signed [63:0] sum;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      z    = (64'(i) * 64'(bif_pkg::LN2_Q30)) / EXP_TABLE_DEPTH;
      term = 64'(bif_pkg::ONE_Q30);
      sum  = 64'(bif_pkg::ONE_Q30);
      for (int k = 1; k <= 16; k++) begin
        term = ((term * z) >> 30) / 64'(k);
        if (k[0]) sum = sum - $signed(term);
        else      sum = sum + $signed(term);
      end
      rom[i] = 17'((64'(sum) + 64'd8192) >> 14);
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

  function automatic logic [8:0] clamp_coord(input logic signed [10:0] v,
                                             input logic [8:0] hi);
    if (v < 0) return 9'd0;
    else if (v > $signed({2'b00, hi})) return hi;
    else return v[8:0];
  endfunction

  typedef enum logic [4:0] {
    S_IDLE, S_GK_SQ, S_GK_MUL, S_GK_WR, S_HOME, S_TAP_WAIT, S_DF, S_CHI, S_CLO,
    S_EXP_CHK, S_EXP_IDX, S_EXP_SH, S_SW, S_WT, S_ACC, S_DIV_INIT, S_DIV_STEP,
    S_DIV_END, S_OUT
  } state_t;

  // Configuration registers.
  logic [8:0]  image_width_r, image_height_r;
  logic [3:0]  window_size_r;
  logic [23:0] spatial_coef_r;
  logic [31:0] color_coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= bif_pkg::RST_IMAGE_WIDTH;
      image_height_r <= bif_pkg::RST_IMAGE_HEIGHT;
      window_size_r  <= bif_pkg::RST_WINDOW_SIZE;
      spatial_coef_r <= bif_pkg::RST_SPATIAL_COEF;
      color_coef_r   <= bif_pkg::RST_COLOR_COEF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bif_pkg::CFG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata[8:0];
        bif_pkg::CFG_IMAGE_HEIGHT: image_height_r <= cfg_wdata[8:0];
        bif_pkg::CFG_WINDOW_SIZE:  window_size_r  <= cfg_wdata[3:0];
        bif_pkg::CFG_SPATIAL_COEF: spatial_coef_r <= cfg_wdata[23:0];
        bif_pkg::CFG_COLOR_COEF:   color_coef_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Datapath and control state.
  state_t                    state_r, exp_ret_r;
  logic [7:0]                x_r, y_r;
  logic [8:0]                wmax_r, hmax_r;
  logic [IW-1:0]             sz_r, half_r, i_r, j_r;
  logic [7:0]                d2_r;
  logic [16:0]               gk_r [MAX_WINDOW];
  logic [16:0]               gx_r, gy_r, sw_r, exp_res_r;
  logic [50:0]               exp_a_r;
  logic [21:0]               b_r;
  logic [MEM_W-1:0]          home_r;
  logic [33:0]               dist2_r;
  logic [32:0]               wt_r;
  logic [1:0]                c_r;
  logic signed [VSUM_W-1:0]  vsum_r [CHANNELS];
  logic [WSUM_W-1:0]         wsum_r, rem_r;
  logic [QB-1:0]             nlo_r, q_r;
  logic [4:0]                cnt_r;
  logic                      neg_r;
  logic signed [15:0]        res_r [bif_pkg::NUM_OUT_CH];
  logic                      out_valid_r;
  bif_pkg::out_item_t        out_data_r;
  logic [AW-1:0]             ra_r;

  // Frame store and exponential table.
  logic [MEM_W-1:0]  frame_mem [MEM_DEPTH];
  logic [MEM_W-1:0]  rd_q_r;
  logic [16:0]       tab_q_r;
  logic              mem_we;
  logic [AW-1:0]     wa;
  logic [MEM_W-1:0]  wd;
  logic [TAB_AW-1:0] tab_idx;
  logic [28:0]       frac_scaled;

  always_ff @(posedge clk) begin
    if (mem_we) frame_mem[wa] <= wd;
    rd_q_r <= frame_mem[ra_r];
  end

  always_ff @(posedge clk) begin
    tab_q_r <= EXP_ROM[tab_idx];
  end

  assign frac_scaled = 29'(b_r[15:0]) * 29'(EXP_TABLE_DEPTH);
  assign tab_idx     = frac_scaled[16 +: TAB_AW];

  // Shared multiplier.
  logic signed [35:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [53:0] prod;
  assign prod = mul_a * mul_b;

  logic                 accept;
  logic [8:0]           wmax_c, hmax_c;
  logic [IW-1:0]        sz_c;
  logic [AW-1:0]        home_addr_c, tap_addr_c;
  logic [IW-1:0]        ni, nj;
  logic                 last_tap;
  logic signed [IW:0]   d_off;
  logic [CH_AW-1:0]     ci;
  logic signed [16:0]   home_s, nb_s, df;
  logic signed [VSUM_W-1:0] div_v;
  logic [VSUM_W-1:0]    div_mag, div_n;
  logic [WSUM_W:0]      div_t;
  logic                 div_ge;
  logic signed [15:0]   sat_val;
  logic [8:0]           nx, ny;
  logic [bif_pkg::SAMPLE_W-1:0] in_samp [bif_pkg::NUM_OUT_CH];

  always_comb begin
    accept = in_stream.valid && in_stream.ready;

    if (image_width_r == 9'd0) wmax_c = 9'd0;
    else if (32'(image_width_r) > MAX_WIDTH) wmax_c = 9'(MAX_WIDTH - 1);
    else wmax_c = image_width_r - 9'd1;
    if (image_height_r == 9'd0) hmax_c = 9'd0;
    else if (32'(image_height_r) > MAX_HEIGHT) hmax_c = 9'(MAX_HEIGHT - 1);
    else hmax_c = image_height_r - 9'd1;
    if (window_size_r == 4'd0) sz_c = IW'(1);
    else if (32'(window_size_r) > MAX_WINDOW) sz_c = IW'(MAX_WINDOW);
    else sz_c = IW'(window_size_r);

    home_addr_c = AW'(32'(clamp_coord(11'(in_stream.data.pos_y), hmax_c)) * MAX_WIDTH
                  + 32'(clamp_coord(11'(in_stream.data.pos_x), wmax_c)));

    // Load path: samples beyond the configured channel count are dropped.
    in_samp[0] = in_stream.data.sample_ch0;
    in_samp[1] = in_stream.data.sample_ch1;
    in_samp[2] = in_stream.data.sample_ch2;
    for (int c = 0; c < CHANNELS; c++) wd[c*SW_ +: SW_] = in_samp[c];
    wa     = AW'(32'(in_stream.data.pos_y) * MAX_WIDTH + 32'(in_stream.data.pos_x));
    mem_we = accept && (in_stream.data.req_type == bif_pkg::REQ_LOAD)
             && (32'(in_stream.data.pos_x) < MAX_WIDTH)
             && (32'(in_stream.data.pos_y) < MAX_HEIGHT);

    // Next tap of the window walk; the home state starts the walk at the corner.
    last_tap = (i_r == sz_r - IW'(1)) && (j_r == sz_r - IW'(1));
    if (state_r == S_HOME) begin
      ni = '0;
      nj = '0;
    end else if (j_r == sz_r - IW'(1)) begin
      ni = i_r + IW'(1);
      nj = '0;
    end else begin
      ni = i_r;
      nj = j_r + IW'(1);
    end
    nx = clamp_coord($signed({3'b000, x_r}) + $signed(11'(ni)) - $signed(11'(half_r)), wmax_r);
    ny = clamp_coord($signed({3'b000, y_r}) + $signed(11'(nj)) - $signed(11'(half_r)), hmax_r);
    tap_addr_c = AW'(32'(ny) * MAX_WIDTH + 32'(nx));

    d_off  = $signed({1'b0, i_r}) - $signed({1'b0, half_r});
    ci     = c_r[CH_AW-1:0];
    home_s = 17'($signed(home_r[32'(ci)*SW_ +: SW_]));
    nb_s   = 17'($signed(rd_q_r[32'(ci)*SW_ +: SW_]));
    df     = home_s - nb_s;

    unique case (state_r)
      S_GK_SQ:   begin mul_a = 36'(d_off);                  mul_b = 18'(d_off);            end
      S_GK_MUL:  begin mul_a = 36'(spatial_coef_r);         mul_b = 18'(d2_r);             end
      S_EXP_CHK: begin mul_a = 36'(exp_a_r[bif_pkg::EXP_ARG_W-1:0]);
                       mul_b = bif_pkg::LOG2E_Q16;                                         end
      S_DF:      begin mul_a = 36'(df);                     mul_b = 18'(df);               end
      S_CHI:     begin mul_a = 36'(dist2_r);                mul_b = 18'(color_coef_r[31:16]); end
      S_CLO:     begin mul_a = 36'(dist2_r);                mul_b = 18'(color_coef_r[15:0]);  end
      S_SW:      begin mul_a = 36'(gx_r);                   mul_b = 18'(gy_r);             end
      S_WT:      begin mul_a = 36'(sw_r);                   mul_b = 18'(exp_res_r);        end
      S_ACC:     begin mul_a = 36'(wt_r);                   mul_b = 18'(nb_s);             end
      default:   begin mul_a = '0;                          mul_b = '0;                    end
    endcase

    // Divider front end: magnitude plus half the divisor, rounding half away from zero.
    div_v   = vsum_r[ci];
    div_mag = div_v[VSUM_W-1] ? VSUM_W'(-div_v) : VSUM_W'(div_v);
    div_n   = div_mag + VSUM_W'(wsum_r >> 1);
    div_t   = {rem_r, nlo_r[QB-1]};
    div_ge  = div_t >= {1'b0, wsum_r};

    if (neg_r) sat_val = (q_r > QB'(32768)) ? 16'sh8000 : 16'(-$signed({1'b0, q_r}));
    else       sat_val = (q_r > QB'(32767)) ? 16'sh7fff : 16'(q_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      exp_ret_r   <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_stream.ready && state_r != S_OUT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept && in_stream.data.req_type == bif_pkg::REQ_FILTER) begin
            x_r    <= in_stream.data.pos_x;
            y_r    <= in_stream.data.pos_y;
            wmax_r <= wmax_c;
            hmax_r <= hmax_c;
            sz_r   <= sz_c;
            half_r <= sz_c >> 1;
            ra_r   <= home_addr_c;
            i_r    <= '0;
            j_r    <= '0;
            wsum_r <= '0;
            for (int c = 0; c < CHANNELS; c++) vsum_r[c] <= '0;
            for (int c = 0; c < bif_pkg::NUM_OUT_CH; c++) res_r[c] <= '0;
            state_r <= S_GK_SQ;
          end
        end
        S_GK_SQ: begin
          d2_r    <= prod[7:0];
          state_r <= S_GK_MUL;
        end
        S_GK_MUL: begin
          exp_a_r   <= 51'(prod[31:0]);
          exp_ret_r <= S_GK_WR;
          state_r   <= S_EXP_CHK;
        end
        S_GK_WR: begin
          gk_r[i_r[GK_AW-1:0]] <= exp_res_r;
          if (i_r == sz_r - IW'(1)) begin
            state_r <= S_HOME;
          end else begin
            i_r     <= i_r + IW'(1);
            state_r <= S_GK_SQ;
          end
        end
        S_HOME: begin
          home_r  <= rd_q_r;
          ra_r    <= tap_addr_c;
          i_r     <= ni;
          j_r     <= nj;
          state_r <= S_TAP_WAIT;
        end
        S_TAP_WAIT: begin
          gx_r    <= gk_r[i_r[GK_AW-1:0]];
          gy_r    <= gk_r[j_r[GK_AW-1:0]];
          dist2_r <= '0;
          c_r     <= '0;
          state_r <= S_DF;
        end
        S_DF: begin
          dist2_r <= dist2_r + prod[33:0];
          if (32'(c_r) == CHANNELS - 1) begin
            state_r <= S_CHI;
          end else begin
            c_r <= c_r + 2'd1;
          end
        end
        S_CHI: begin
          exp_a_r <= prod[50:0];
          state_r <= S_CLO;
        end
        S_CLO: begin
          exp_a_r   <= exp_a_r + 51'(prod[53:16]);
          exp_ret_r <= S_SW;
          state_r   <= S_EXP_CHK;
        end
        S_EXP_CHK: begin
          if (|exp_a_r[50:bif_pkg::EXP_ARG_W]) begin
            exp_res_r <= '0;
            state_r   <= exp_ret_r;
          end else begin
            b_r     <= prod[37:16];
            state_r <= S_EXP_IDX;
          end
        end
        S_EXP_IDX: begin
          // The table read for b_r is under way; shifts of 32 or more give zero.
          if (b_r[21]) begin
            exp_res_r <= '0;
            state_r   <= exp_ret_r;
          end else begin
            state_r <= S_EXP_SH;
          end
        end
        S_EXP_SH: begin
          exp_res_r <= tab_q_r >> b_r[20:16];
          state_r   <= exp_ret_r;
        end
        S_SW: begin
          sw_r    <= prod[32:16];
          state_r <= S_WT;
        end
        S_WT: begin
          wt_r    <= prod[32:0];
          wsum_r  <= wsum_r + WSUM_W'(prod[32:0]);
          c_r     <= '0;
          state_r <= S_ACC;
        end
        S_ACC: begin
          vsum_r[ci] <= vsum_r[ci] + VSUM_W'(prod);
          if (32'(c_r) == CHANNELS - 1) begin
            c_r <= '0;
            if (last_tap) begin
              state_r <= S_DIV_INIT;
            end else begin
              ra_r    <= tap_addr_c;
              i_r     <= ni;
              j_r     <= nj;
              state_r <= S_TAP_WAIT;
            end
          end else begin
            c_r <= c_r + 2'd1;
          end
        end
        S_DIV_INIT: begin
          neg_r   <= div_v[VSUM_W-1];
          rem_r   <= WSUM_W'(div_n >> QB);
          nlo_r   <= div_n[QB-1:0];
          q_r     <= '0;
          cnt_r   <= '0;
          state_r <= S_DIV_STEP;
        end
        S_DIV_STEP: begin
          if (div_ge) begin
            rem_r <= WSUM_W'(div_t - {1'b0, wsum_r});
            q_r   <= {q_r[QB-2:0], 1'b1};
          end else begin
            rem_r <= WSUM_W'(div_t);
            q_r   <= {q_r[QB-2:0], 1'b0};
          end
          nlo_r <= nlo_r << 1;
          cnt_r <= cnt_r + 5'd1;
          if (32'(cnt_r) == QB - 1) state_r <= S_DIV_END;
        end
        S_DIV_END: begin
          res_r[c_r] <= sat_val;
          if (32'(c_r) == CHANNELS - 1) begin
            state_r <= S_OUT;
          end else begin
            c_r     <= c_r + 2'd1;
            state_r <= S_DIV_INIT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_stream.ready) begin
            out_data_r.out_x        <= x_r;
            out_data_r.out_y        <= y_r;
            out_data_r.filtered_ch0 <= res_r[0];
            out_data_r.filtered_ch1 <= res_r[1];
            out_data_r.filtered_ch2 <= res_r[2];
            out_valid_r             <= 1'b1;
            state_r                 <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stream.ready  = (state_r == S_IDLE);
  assign out_stream.valid = out_valid_r;
  assign out_stream.data  = out_data_r;

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_stream.data.req_type == bif_pkg::REQ_LOAD) |=> state_r == S_IDLE)
    else $error("load transaction started filter work");

  a_div_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_STEP) |-> (rem_r < wsum_r))
    else $error("divider remainder not below the weight sum");

  a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SW) |-> (exp_res_r <= bif_pkg::EXP_ONE))
    else $error("exponential result above one");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result shown without a finished filter transaction");

endmodule
